/* hw/rtl/psq_pkg.sv */
package psq_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned NormW  = 16;
  localparam int unsigned MagW   = 15;
  localparam int unsigned OutW   = 20;
  localparam int unsigned ThickW = 12;
  localparam int unsigned OffW   = 13;
  localparam int unsigned SumW   = 33;
  localparam int unsigned MulAW  = 32;
  localparam int unsigned MulBW  = 18;
  localparam int unsigned MulPW  = MulAW + MulBW;
  localparam int unsigned BitW   = 4;

  localparam logic [ThickW-1:0] ThickReset = ThickW'(16);

  // one stroke edge: top x, top y, bottom x, bottom y
  typedef struct packed {
    logic signed [OutW-1:0] bot_y;
    logic signed [OutW-1:0] bot_x;
    logic signed [OutW-1:0] top_y;
    logic signed [OutW-1:0] top_x;
  } edge_t;

  // one quad word toward the output queue
  typedef struct packed {
    edge_t start;
    edge_t stop;
    logic  fin;
  } quad_t;

endpackage

/* hw/rtl/psq_mul.sv */
module psq_mul
  import psq_pkg::*;
(
  input  logic               clk_i,
  input  logic [MulAW-1:0]   a_i,
  input  logic [MulBW-1:0]   b_i,
  output logic [MulPW-1:0]   p_o
);

  logic [MulPW-1:0] p_q;

  // shared unsigned multiplier, registered product
  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/psq_seq.sv */
module psq_seq
  import psq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] in_x_i,
  input  logic signed [CoordW-1:0] in_y_i,
  input  logic                     in_last_i,
  input  logic [ThickW-1:0]        thick_i,
  output logic                     push_o,
  output quad_t                    quad_o,
  input  logic                     full_i
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_DIFF, ST_SQX, ST_SQY, ST_SSUM, ST_RHS0, ST_RHS1,
    ST_T1, ST_T2, ST_T3, ST_T4, ST_OX, ST_OY, ST_OFIN, ST_EDGE, ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    JOB_FIRST, JOB_JOINT, JOB_END
  } job_e;

  state_e state_q;
  job_e   job_q;
  logic [1:0] pts_q;
  logic comp_q;
  logic signed [CoordW-1:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q;
  logic last_q;
  logic signed [NormW-1:0] nx_q, ny_q, pn_x_q, pn_y_q;
  logic [CoordW-1:0] ax_q, ay_q;
  logic sx_q, sy_q;
  logic [SumW-1:0] s_q;
  logic [31:0] rhs_q, sq_q;
  logic [MulPW-1:0] plo_q;
  logic [MagW-1:0] m_q, cand_q;
  logic [BitW-1:0] k_q;
  logic signed [OffW-1:0] ox_q, oy_q;
  edge_t open_q;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] p;

  psq_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p)
  );

  logic signed [CoordW:0] dx, dy;
  logic [MagW-1:0] cand, m_new;
  logic [CoordW-1:0] odd;
  logic [67:0] total;
  logic fit;
  logic signed [CoordW:0] nsel_x, nsel_y;
  logic [CoordW:0] nmag_x, nmag_y;
  logic sh16;
  logic [27:0] rnd_mag;
  logic [OffW-1:0] rnd_val;
  logic signed [OffW-1:0] off_new;
  logic signed [CoordW-1:0] px, py;
  edge_t edge_new;

  always_comb begin
    dx = {cur_x_q[CoordW-1], cur_x_q} - {prev_x_q[CoordW-1], prev_x_q};
    dy = {cur_y_q[CoordW-1], cur_y_q} - {prev_y_q[CoordW-1], prev_y_q};
    cand = m_q | (MagW'(1) << k_q);
    odd = {cand, 1'b0} - CoordW'(1);
    total = {p, 18'b0} + 68'(plo_q);
    fit = total <= {4'b0, rhs_q, 32'b0};
    m_new = fit ? cand_q : m_q;
    sh16 = (job_q == JOB_JOINT);
    if (sh16) begin
      nsel_x = {pn_x_q[NormW-1], pn_x_q} + {nx_q[NormW-1], nx_q};
      nsel_y = {pn_y_q[NormW-1], pn_y_q} + {ny_q[NormW-1], ny_q};
    end else begin
      nsel_x = {nx_q[NormW-1], nx_q};
      nsel_y = {ny_q[NormW-1], ny_q};
    end
    nmag_x = nsel_x[CoordW] ? (CoordW+1)'(-nsel_x) : nsel_x;
    nmag_y = nsel_y[CoordW] ? (CoordW+1)'(-nsel_y) : nsel_y;
    // round half away from zero on the magnitude, then restore the sign
    rnd_mag = p[27:0];
    if (sh16) rnd_val = OffW'((rnd_mag + 28'(1 << 15)) >> 16);
    else      rnd_val = OffW'((rnd_mag + 28'(1 << 14)) >> 15);
    if (state_q == ST_OY) off_new = nsel_x[CoordW] ? -signed'(rnd_val) : signed'(rnd_val);
    else                  off_new = nsel_y[CoordW] ? -signed'(rnd_val) : signed'(rnd_val);
    px = (job_q == JOB_END) ? cur_x_q : prev_x_q;
    py = (job_q == JOB_END) ? cur_y_q : prev_y_q;
    // offsets stay within 4095, so the 20 bit results never saturate
    edge_new.top_x = {{(OutW-CoordW){px[CoordW-1]}}, px} - {{(OutW-OffW){ox_q[OffW-1]}}, ox_q};
    edge_new.top_y = {{(OutW-CoordW){py[CoordW-1]}}, py} - {{(OutW-OffW){oy_q[OffW-1]}}, oy_q};
    edge_new.bot_x = {{(OutW-CoordW){px[CoordW-1]}}, px} + {{(OutW-OffW){ox_q[OffW-1]}}, ox_q};
    edge_new.bot_y = {{(OutW-CoordW){py[CoordW-1]}}, py} + {{(OutW-OffW){oy_q[OffW-1]}}, oy_q};
  end

  // multiplier operands by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQX:  begin mul_a = MulAW'(ax_q); mul_b = MulBW'(ax_q); end
      ST_SQY:  begin mul_a = MulAW'(ay_q); mul_b = MulBW'(ay_q); end
      ST_RHS0: begin
        mul_a = MulAW'(comp_q ? ax_q : ay_q);
        mul_b = MulBW'(comp_q ? ax_q : ay_q);
      end
      ST_T1:   begin mul_a = MulAW'(odd); mul_b = MulBW'(odd); end
      ST_T2:   begin mul_a = p[31:0]; mul_b = s_q[17:0]; end
      ST_T3:   begin mul_a = sq_q; mul_b = MulBW'(s_q[SumW-1:18]); end
      ST_OX:   begin mul_a = MulAW'(thick_i); mul_b = MulBW'(nmag_x); end
      ST_OY:   begin mul_a = MulAW'(thick_i); mul_b = MulBW'(nmag_y); end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign push_o = (state_q == ST_EDGE) && (job_q != JOB_FIRST) && !full_i;
  assign quad_o = '{start: open_q, stop: edge_new, fin: (job_q == JOB_END)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      job_q    <= JOB_FIRST;
      pts_q    <= '0;
      comp_q   <= 1'b0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      pn_x_q   <= '0;
      pn_y_q   <= '0;
      open_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cur_x_q <= in_x_i;
            cur_y_q <= in_y_i;
            last_q  <= in_last_i;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (pts_q == 2'd0 || pts_q == 2'd3) begin
            prev_x_q <= cur_x_q;
            prev_y_q <= cur_y_q;
            pts_q    <= last_q ? 2'd0 : 2'd1;
            state_q  <= ST_IDLE;
          end else begin
            state_q <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          ax_q <= dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
          ay_q <= dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
          sx_q <= dy[CoordW];
          sy_q <= dx[CoordW];
          state_q <= ST_SQX;
        end
        ST_SQX: state_q <= ST_SQY;
        ST_SQY: begin
          s_q <= SumW'(p);
          state_q <= ST_SSUM;
        end
        ST_SSUM: begin
          s_q <= s_q + SumW'(p);
          comp_q <= 1'b0;
          state_q <= ST_RHS0;
        end
        ST_RHS0: begin
          if (s_q == '0) begin
            // zero-length segment: zero normal
            nx_q <= '0;
            ny_q <= '0;
            job_q <= (pts_q == 2'd1) ? JOB_FIRST : JOB_JOINT;
            state_q <= ST_OX;
          end else begin
            state_q <= ST_RHS1;
          end
        end
        ST_RHS1: begin
          rhs_q <= p[31:0];
          m_q <= '0;
          k_q <= BitW'(MagW - 1);
          state_q <= ST_T1;
        end
        ST_T1: begin
          cand_q <= cand;
          state_q <= ST_T2;
        end
        ST_T2: begin
          sq_q <= p[31:0];
          state_q <= ST_T3;
        end
        ST_T3: begin
          plo_q <= p;
          state_q <= ST_T4;
        end
        ST_T4: begin
          m_q <= m_new;
          if (k_q == '0) begin
            if (!comp_q) begin
              nx_q <= sx_q ? -signed'({1'b0, m_new}) : signed'({1'b0, m_new});
              comp_q <= 1'b1;
              state_q <= ST_RHS0;
            end else begin
              ny_q <= sy_q ? signed'({1'b0, m_new}) : -signed'({1'b0, m_new});
              job_q <= (pts_q == 2'd1) ? JOB_FIRST : JOB_JOINT;
              state_q <= ST_OX;
            end
          end else begin
            k_q <= k_q - BitW'(1);
            state_q <= ST_T1;
          end
        end
        ST_OX: state_q <= ST_OY;
        ST_OY: begin
          ox_q <= off_new;
          state_q <= ST_OFIN;
        end
        ST_OFIN: begin
          oy_q <= off_new;
          state_q <= ST_EDGE;
        end
        ST_EDGE: begin
          if (job_q == JOB_FIRST) begin
            open_q <= edge_new;
            if (last_q) begin
              job_q <= JOB_END;
              state_q <= ST_OX;
            end else begin
              state_q <= ST_FIN;
            end
          end else if (!full_i) begin
            open_q <= edge_new;
            if (job_q == JOB_JOINT && last_q) begin
              job_q <= JOB_END;
              state_q <= ST_OX;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          prev_x_q <= cur_x_q;
          prev_y_q <= cur_y_q;
          pn_x_q <= nx_q;
          pn_y_q <= ny_q;
          pts_q <= last_q ? 2'd0 : 2'd2;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/polyline_stroke_quad_expander.sv */
// polyline stroke quad expander
// s_axis: one path point per word, tdata = {point_y, point_x}, tlast marks
// the last point of a path. m_axis: one quad per word, tlast set on the
// final quad of a path.
// cfg_we_i/cfg_wdata_i write the stroke half-width (unsigned q8.4);
// write it only while the block is idle.
// every accepted point drops s_axis_tready until the sequencer is done;
// the first point of a path is only stored. later points run through one
// shared 32x18 multiplier under a sequencer: the segment length, then two
// normal components unless it is zero (bitwise search of the reciprocal
// root over 15 bits, four steps per bit), then ST_OX, ST_OY, ST_OFIN and
// ST_EDGE per stroke edge and ST_FIN to finish.
// quads wait in a two word output queue, so the receiver may stall while
// the next point is processed; the sequencer holds only when it must push
// into a full queue.
// reset empties the queue, clears the path state and loads a thickness
// of 1.0 pixel.
module polyline_stroke_quad_expander
  import psq_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,   // point_x, point_y
  input  logic          s_axis_tlast,   // path_last
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // top_left_x, top_left_y, top_right_x, top_right_y,
  // bottom_right_x, bottom_right_y, bottom_left_x, bottom_left_y
  output logic [159:0]  m_axis_tdata,
  output logic          m_axis_tlast,   // quad_is_final
  input  logic          cfg_we_i,
  input  logic [ThickW-1:0] cfg_wdata_i
);

  logic [ThickW-1:0] thick_q;
  quad_t slot_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  logic push, pop;
  quad_t quad, head;

  // stroke thickness register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thick_q <= ThickReset;
    end else if (cfg_we_i) begin
      thick_q <= cfg_wdata_i;
    end
  end

  psq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_x_i     (s_axis_tdata[15:0]),
    .in_y_i     (s_axis_tdata[31:16]),
    .in_last_i  (s_axis_tlast),
    .thick_i    (thick_q),
    .push_o     (push),
    .quad_o     (quad),
    .full_i     (cnt_q == 2'd2)
  );

  // two word output queue
  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= quad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign head = slot_q[rd_q];
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tlast  = head.fin;
  assign m_axis_tdata  = {head.start.bot_y, head.start.bot_x,
                          head.stop.bot_y,  head.stop.bot_x,
                          head.stop.top_y,  head.stop.top_x,
                          head.start.top_y, head.start.top_x};

endmodule

/* hw/rtl/psq_checker.sv */
module psq_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [159:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output word changed under stall");

  // every accepted point makes the sequencer busy, so ready drops after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accept");

  // quads only come from a busy sequencer
  a_rose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !s_axis_tready)
    else $error("quad appeared while idle");

endmodule

bind polyline_stroke_quad_expander psq_checker u_psq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* verif/polyline_stroke_quad_checker.sv */
`timescale 1ns / 1ps

module polyline_stroke_quad_checker
  import psq_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  input  logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,
  input  logic          s_axis_tlast,
  input  logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic [159:0]  m_axis_tdata,
  input  logic          m_axis_tlast,
  input  logic          cfg_we_i,
  input  logic [ThickW-1:0] cfg_wdata_i,
  output int            fail_count_o,
  output int            pending_o
);

  typedef struct {
    logic [OutW-1:0] vtx[8];
    logic            fin;
  } quad_word_t;

  quad_word_t quad_expect_q[$];

  longint thick;
  int     pts_held;
  longint last_pt[2];
  longint last_nrm[2];
  longint open_edge[4];

  string field_name[9] = '{"top_left_x", "top_left_y", "top_right_x", "top_right_y",
    "bottom_right_x", "bottom_right_y", "bottom_left_x", "bottom_left_y", "quad_is_final"};

  // nearest a * 2^15 / sqrt(s), ties up, saturated
  function automatic longint unit_mag(longint a, longint s);
    logic [95:0] rhs, lhs;
    longint lo, hi, mid, odd;
    rhs = 96'(a * a) << 32;
    lo = 0;
    hi = 1 << MagW;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 2 * mid - 1;
      lhs = 96'(odd * odd) * 96'(s);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (lo > (1 << MagW) - 1) lo = (1 << MagW) - 1;
    return lo;
  endfunction

  function automatic void seg_normal(longint dx, longint dy, output longint nx,
                                     output longint ny);
    longint ax, ay, s, mx, my;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    while (ax >= (1 << 17) || ay >= (1 << 17)) begin
      ax = ax >> 1;
      ay = ay >> 1;
    end
    s = ax * ax + ay * ay;
    nx = 0;
    ny = 0;
    if (s != 0) begin
      mx = unit_mag(ay, s);
      my = unit_mag(ax, s);
      nx = dy < 0 ? -mx : mx;
      ny = dx < 0 ? my : -my;
    end
  endfunction

  // round half away from zero
  function automatic longint offset_of(longint n, int sh);
    longint v, mag, r;
    v = n * thick;
    mag = v < 0 ? -v : v;
    r = (mag + (longint'(1) << (sh - 1))) >>> sh;
    return v < 0 ? -r : r;
  endfunction

  function automatic longint sat20(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic void make_edge(longint px, longint py, longint ox, longint oy,
                                    output longint e[4]);
    e[0] = sat20(px - ox);
    e[1] = sat20(py - oy);
    e[2] = sat20(px + ox);
    e[3] = sat20(py + oy);
  endfunction

  function automatic quad_word_t form_quad(longint st[4], longint en[4], logic fin);
    quad_word_t q;
    q.vtx[0] = st[0][OutW-1:0];
    q.vtx[1] = st[1][OutW-1:0];
    q.vtx[2] = en[0][OutW-1:0];
    q.vtx[3] = en[1][OutW-1:0];
    q.vtx[4] = en[2][OutW-1:0];
    q.vtx[5] = en[3][OutW-1:0];
    q.vtx[6] = st[2][OutW-1:0];
    q.vtx[7] = st[3][OutW-1:0];
    q.fin = fin;
    return q;
  endfunction

  task automatic predict_point(longint x, longint y, logic last);
    longint nx, ny;
    longint jnt[4], endv[4];
    if (pts_held == 0) begin
      pts_held = last ? 0 : 1;
    end else begin
      seg_normal(x - last_pt[0], y - last_pt[1], nx, ny);
      if (pts_held == 1) begin
        make_edge(last_pt[0], last_pt[1], offset_of(nx, 15), offset_of(ny, 15), open_edge);
      end else begin
        make_edge(last_pt[0], last_pt[1], offset_of(last_nrm[0] + nx, 16),
                  offset_of(last_nrm[1] + ny, 16), jnt);
        quad_expect_q.push_back(form_quad(open_edge, jnt, 1'b0));
        open_edge = jnt;
      end
      if (last) begin
        make_edge(x, y, offset_of(nx, 15), offset_of(ny, 15), endv);
        quad_expect_q.push_back(form_quad(open_edge, endv, 1'b1));
        pts_held = 0;
      end else begin
        pts_held = 2;
      end
      last_nrm[0] = nx;
      last_nrm[1] = ny;
    end
    last_pt[0] = x;
    last_pt[1] = y;
  endtask

  task automatic check_quad();
    quad_word_t want;
    logic [OutW-1:0] got[9];
    logic [OutW-1:0] exp_f[9];
    bit bad;
    for (int i = 0; i < 8; i++) got[i] = m_axis_tdata[i*OutW +: OutW];
    got[8] = OutW'(m_axis_tlast);
    if (quad_expect_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) $display("unexpected quad word %h", m_axis_tdata);
    end else begin
      want = quad_expect_q.pop_front();
      for (int i = 0; i < 8; i++) exp_f[i] = want.vtx[i];
      exp_f[8] = OutW'(want.fin);
      bad = 0;
      for (int i = 0; i < 9; i++) begin
        if (got[i] !== exp_f[i]) begin
          if (!bad) fail_count_o++;
          bad = 1;
          if (fail_count_o <= 10)
            $display("quad mismatch %s: expected %h actual %h", field_name[i],
                     exp_f[i], got[i]);
        end
      end
    end
  endtask

  assign pending_o = quad_expect_q.size();

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thick = ThickReset;
      pts_held = 0;
      last_pt = '{0, 0};
      last_nrm = '{0, 0};
      open_edge = '{0, 0, 0, 0};
      quad_expect_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_quad();
      if (s_axis_tvalid && s_axis_tready)
        predict_point(longint'($signed(s_axis_tdata[15:0])),
                      longint'($signed(s_axis_tdata[31:16])), s_axis_tlast);
      if (cfg_we_i) thick = cfg_wdata_i;
    end
  end

endmodule

/* verif/polyline_stroke_quad_expander_tb.sv */
`timescale 1ns / 1ps

module polyline_stroke_quad_expander_tb
  import psq_pkg::*;
;

  localparam int IdleLimit = 20000;
  localparam int SettleCycles = 400;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // point_x, point_y
  logic s_axis_tlast = 0;           // path_last
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  // top_left_x, top_left_y, top_right_x, top_right_y,
  // bottom_right_x, bottom_right_y, bottom_left_x, bottom_left_y
  logic [159:0] m_axis_tdata;
  logic m_axis_tlast;               // quad_is_final
  logic cfg_we_i = 0;
  logic [ThickW-1:0] cfg_wdata_i = '0;

  int fail_count, pending;
  int points_sent = 0;
  int burst_left = 0;
  int stall_pct = 0;
  int stall_cycle = 0;
  int idle_cycles = 0;
  bit rx_hold = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  polyline_stroke_quad_expander dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_wdata_i
  );

  polyline_stroke_quad_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: stall rate is redrawn on a stall_cycle schedule, zero included
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 500 == 0) stall_pct <= ($urandom_range(0, 3) == 0) ? 0 :
                                             $urandom_range(10, 80);
    if (rx_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // long hold-off so the output queue fills and the input backs up
  initial begin
    wait (points_sent >= 300);
    @(posedge clk_i);
    rx_hold = 1;
    repeat (3000) @(posedge clk_i);
    rx_hold = 0;
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one word into s_axis; valid stays high inside a burst
  task automatic send_point(logic [15:0] x, logic [15:0] y, logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    points_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drain all quads, then let a point without a quad finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_thickness(logic [ThickW-1:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic corner_path();
    send_point(16'h8000, 16'h8000, 0);
    send_point(16'h7fff, 16'h7fff, 0);
    send_point(16'h8000, 16'h7fff, 0);
    send_point(16'h7fff, 16'h8000, 1);
  endtask

  // random paths; may stop with a path still open
  task automatic random_paths(int n);
    int cnt, len, pick;
    int px, py;
    cnt = 0;
    while (cnt < n) begin
      pick = $urandom_range(0, 9);
      len = (pick == 0) ? 1 : $urandom_range(2, 10);
      px = $urandom;
      py = $urandom;
      for (int i = 0; i < len && cnt < n; i++) begin
        pick = $urandom_range(0, 99);
        if (i > 0) begin
          if (pick < 70) begin
            px = px + $urandom_range(0, 128) - 64;
            py = py + $urandom_range(0, 128) - 64;
          end else if (pick >= 85) begin
            px = $urandom;
            py = $urandom;
          end
        end
        send_point(px[15:0], py[15:0], i == len - 1);
        cnt++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // single point path, straight segment, zero-length segments, a bend
    send_point(16'd0, 16'd0, 1);
    send_point(16'd0, 16'd0, 0);
    send_point(16'd160, 16'd0, 1);
    send_point(16'd5, 16'd5, 0);
    send_point(16'd5, 16'd5, 0);
    send_point(16'd5, 16'd5, 1);
    send_point(16'd0, 16'd0, 0);
    send_point(16'd100, 16'd0, 0);
    send_point(16'd100, 16'd100, 1);
    corner_path();
    set_thickness(12'hfff);
    corner_path();
    send_point(16'hfff0, 16'd3, 0);
    send_point(16'd40, 16'hffd0, 1);
    set_thickness(12'd0);
    send_point(16'd1, 16'd2, 0);
    send_point(16'd9, 16'd7, 1);

    // random phases; a path left open carries across a thickness change
    set_thickness(12'd16);
    random_paths(220);
    set_thickness(12'hfff);
    random_paths(220);
    set_thickness(12'd0);
    random_paths(200);
    set_thickness(12'd1);
    random_paths(220);
    set_thickness(12'($urandom));
    random_paths(220);
    send_point(16'd0, 16'd0, 1);

    wait_idle();
    if (fail_count == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/psq_pkg.sv
hw/rtl/psq_mul.sv
hw/rtl/psq_seq.sv
hw/rtl/polyline_stroke_quad_expander.sv
hw/rtl/psq_checker.sv
verif/polyline_stroke_quad_checker.sv
verif/polyline_stroke_quad_expander_tb.sv
